// File: design/zpc_pkg.sv
package zpc_pkg;

  // Default store dimensions.
  localparam int DEF_MAX_ROWS   = 128;
  localparam int DEF_MAX_COLS   = 128;
  localparam int DEF_MAX_KERNEL = 16;

  // Field and register widths.
  localparam int OP_W    = 2;
  localparam int IDX_W   = 7;
  localparam int DATA_W  = 16;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int SUM_W   = 48;
  localparam int DIM_W   = 8;
  localparam int KSIZE_W = 5;
  localparam int CFG_W   = 8;
  localparam int CIDX_W  = 2;
  // Signed window coordinate: covers row minus half kernel plus kernel offset.
  localparam int COORD_W = 10;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_KERNEL = 2'd0;
  localparam logic [OP_W-1:0] OP_PIXEL  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_IMAGE_ROWS  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_IMAGE_COLS  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_KERNEL_SIZE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } ctrl_state_t;

  // One kernel tap travelling down the multiply-accumulate pipeline.
  typedef struct packed {
    logic issue;
    logic ok;
    logic first;
    logic last;
  } tap_t;

endpackage

// File: design/zero_padded_2d_convolution_core.sv
// Zero-padded same-size 2D convolution core.
//
// Items arrive on a command channel: an item transfers at a rising clock edge
// where start is high and busy is low. opcode selects a kernel coefficient
// write, an image pixel write or an output query; opcode 3 does nothing.
// Writes complete in the transfer cycle and never raise busy, so while no
// query runs a write may follow every cycle. A query raises busy while it
// runs one multiply-accumulate per kernel tap, reading image and kernel
// memories in lockstep. With K the kernel size in use, done pulses for one
// cycle once all K*K taps have been accumulated, carrying out_row, out_col
// and conv_sum; busy drops in the following cycle, and no new item is taken
// before then. The single read port of each memory allows one tap a cycle.
// The receiver cannot stall: the result must be taken in its strobe cycle.
// Configuration writes take effect at once and should be made while idle.
// Reset returns the size registers to one and the controller to idle; the
// memories are not cleared, and a query must only touch written entries.
module zero_padded_2d_convolution_core #(
  parameter int MAX_ROWS   = zpc_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = zpc_pkg::DEF_MAX_COLS,
  parameter int MAX_KERNEL = zpc_pkg::DEF_MAX_KERNEL
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [zpc_pkg::OP_W-1:0]           opcode,
  input  logic [zpc_pkg::IDX_W-1:0]          row_index,
  input  logic [zpc_pkg::IDX_W-1:0]          col_index,
  input  logic signed [zpc_pkg::DATA_W-1:0]  data_value,
  output logic                               done,
  output logic [zpc_pkg::IDX_W-1:0]          out_row,
  output logic [zpc_pkg::IDX_W-1:0]          out_col,
  output logic signed [zpc_pkg::SUM_W-1:0]   conv_sum,
  input  logic                               cfg_we,
  input  logic [zpc_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [zpc_pkg::CFG_W-1:0]          cfg_data
);

  import zpc_pkg::*;

  localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int KER_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int IMG_AW = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int KER_AW = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;

  logic [DIM_W-1:0]   image_rows;
  logic [DIM_W-1:0]   image_cols;
  logic [KSIZE_W-1:0] kernel_size;
  logic [DIM_W-1:0]   rows_use;
  logic [DIM_W-1:0]   cols_use;
  logic [KSIZE_W-1:0] ks_use;

  logic accept, start_query, img_we, ker_we, sum_done;
  logic [IMG_AW-1:0] img_waddr, img_raddr;
  logic [KER_AW-1:0] ker_waddr, ker_raddr;
  logic signed [DATA_W-1:0] img_rdata, ker_rdata;
  tap_t tap;

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows  <= DIM_W'(1);
      image_cols  <= DIM_W'(1);
      kernel_size <= KSIZE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_ROWS:  image_rows  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_COLS:  image_cols  <= cfg_data[DIM_W-1:0];
        REG_KERNEL_SIZE: kernel_size <= cfg_data[KSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sizes in use saturate to the range the memories can hold.
  always_comb begin
    if (image_rows == '0) begin
      rows_use = DIM_W'(1);
    end else if (int'(image_rows) > MAX_ROWS) begin
      rows_use = DIM_W'(MAX_ROWS);
    end else begin
      rows_use = image_rows;
    end
    if (image_cols == '0) begin
      cols_use = DIM_W'(1);
    end else if (int'(image_cols) > MAX_COLS) begin
      cols_use = DIM_W'(MAX_COLS);
    end else begin
      cols_use = image_cols;
    end
    if (kernel_size == '0) begin
      ks_use = KSIZE_W'(1);
    end else if (int'(kernel_size) > MAX_KERNEL) begin
      ks_use = KSIZE_W'(MAX_KERNEL);
    end else begin
      ks_use = kernel_size;
    end
  end

  // Writes go straight into the memories in the transfer cycle; a write that
  // falls outside its store is dropped.
  always_comb begin
    accept      = start && !busy;
    start_query = accept && (opcode == OP_QUERY);
    ker_we = accept && (opcode == OP_KERNEL) &&
             (int'(row_index) < MAX_KERNEL) && (int'(col_index) < MAX_KERNEL);
    img_we = accept && (opcode == OP_PIXEL) &&
             (int'(row_index) < MAX_ROWS) && (int'(col_index) < MAX_COLS);
    ker_waddr = KER_AW'(int'(row_index) * MAX_KERNEL + int'(col_index));
    img_waddr = IMG_AW'(int'(row_index) * MAX_COLS + int'(col_index));
  end

  zpc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (IMG_DEPTH)
  ) u_img_ram (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (data_value),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  zpc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (KER_DEPTH)
  ) u_ker_ram (
    .clk   (clk),
    .we    (ker_we),
    .waddr (ker_waddr),
    .wdata (data_value),
    .raddr (ker_raddr),
    .rdata (ker_rdata)
  );

  // The sequencer walks the kernel taps and holds busy until the sum is out.
  zpc_ctrl #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start_query (start_query),
    .row_index   (row_index),
    .col_index   (col_index),
    .rows_use    (rows_use),
    .cols_use    (cols_use),
    .ks_use      (ks_use),
    .sum_done    (sum_done),
    .busy        (busy),
    .tap         (tap),
    .img_raddr   (img_raddr),
    .ker_raddr   (ker_raddr),
    .q_row       (out_row),
    .q_col       (out_col)
  );

  // Memory read, product register, then accumulate.
  zpc_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .tap       (tap),
    .img_rdata (img_rdata),
    .ker_rdata (ker_rdata),
    .acc       (conv_sum),
    .sum_done  (sum_done)
  );

  assign done = sum_done;

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a running query");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == OP_QUERY |=> busy)
    else $error("accepted query did not raise busy");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !done)
    else $error("result strobe without a query in progress");

endmodule

// File: design/zpc_ram.sv
module zpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/zpc_ctrl.sv
module zpc_ctrl #(
  parameter int MAX_ROWS   = zpc_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = zpc_pkg::DEF_MAX_COLS,
  parameter int MAX_KERNEL = zpc_pkg::DEF_MAX_KERNEL,
  localparam int IMG_AW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1,
  localparam int KER_AW = (MAX_KERNEL * MAX_KERNEL > 1) ?
                          $clog2(MAX_KERNEL * MAX_KERNEL) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start_query,
  input  logic [zpc_pkg::IDX_W-1:0]    row_index,
  input  logic [zpc_pkg::IDX_W-1:0]    col_index,
  input  logic [zpc_pkg::DIM_W-1:0]    rows_use,
  input  logic [zpc_pkg::DIM_W-1:0]    cols_use,
  input  logic [zpc_pkg::KSIZE_W-1:0]  ks_use,
  input  logic                         sum_done,
  output logic                         busy,
  output zpc_pkg::tap_t                tap,
  output logic [IMG_AW-1:0]            img_raddr,
  output logic [KER_AW-1:0]            ker_raddr,
  output logic [zpc_pkg::IDX_W-1:0]    q_row,
  output logic [zpc_pkg::IDX_W-1:0]    q_col
);

  import zpc_pkg::*;

  ctrl_state_t state, state_next;
  logic [DIM_W-1:0]   rows;
  logic [DIM_W-1:0]   cols;
  logic [KSIZE_W-1:0] ks;
  logic [KSIZE_W-1:0] half;
  logic [KSIZE_W-1:0] ki;
  logic [KSIZE_W-1:0] kj;
  logic signed [COORD_W-1:0] pr;
  logic signed [COORD_W-1:0] pc;
  logic row_ok, col_ok, last_col, last_tap;

  // Window coordinates of the current tap.
  always_comb begin
    pr = $signed(COORD_W'(q_row)) - $signed(COORD_W'(half)) + $signed(COORD_W'(ki));
    pc = $signed(COORD_W'(q_col)) - $signed(COORD_W'(half)) + $signed(COORD_W'(kj));
    row_ok   = (pr >= 0) && (pr < $signed(COORD_W'(rows)));
    col_ok   = (pc >= 0) && (pc < $signed(COORD_W'(cols)));
    last_col = (kj == ks - KSIZE_W'(1));
    last_tap = last_col && (ki == ks - KSIZE_W'(1));
  end

  // Padding taps read address zero and are discarded downstream.
  always_comb begin
    if (row_ok && col_ok) begin
      img_raddr = IMG_AW'(int'(unsigned'(pr)) * MAX_COLS + int'(unsigned'(pc)));
    end else begin
      img_raddr = '0;
    end
    ker_raddr = KER_AW'(int'(ki) * MAX_KERNEL + int'(kj));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start_query) state_next = ST_ISSUE;
      ST_ISSUE: if (last_tap) state_next = ST_WAIT;
      ST_WAIT:  if (sum_done) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != ST_IDLE);
    tap.issue = (state == ST_ISSUE);
    tap.ok    = row_ok && col_ok;
    tap.first = (ki == '0) && (kj == '0);
    tap.last  = last_tap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ki    <= '0;
      kj    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && start_query) begin
        ki <= '0;
        kj <= '0;
      end else if (state == ST_ISSUE) begin
        if (last_col) begin
          kj <= '0;
          ki <= ki + KSIZE_W'(1);
        end else begin
          kj <= kj + KSIZE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start_query) begin
      q_row <= row_index;
      q_col <= col_index;
      rows  <= rows_use;
      cols  <= cols_use;
      ks    <= ks_use;
      half  <= ks_use >> 1;
    end
  end

  a_tap_in_kernel: assert property (@(posedge clk) disable iff (rst)
    state == ST_ISSUE |-> (ki < ks && kj < ks))
    else $error("kernel tap counter beyond kernel size");

endmodule

// File: design/zpc_mac.sv
module zpc_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  zpc_pkg::tap_t                      tap,
  input  logic signed [zpc_pkg::DATA_W-1:0]  img_rdata,
  input  logic signed [zpc_pkg::DATA_W-1:0]  ker_rdata,
  output logic signed [zpc_pkg::SUM_W-1:0]   acc,
  output logic                               sum_done
);

  import zpc_pkg::*;

  tap_t tap_d1, tap_d2;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  term;

  always_comb begin
    term = tap_d2.ok ? SUM_W'(prod) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_d1   <= '0;
      tap_d2   <= '0;
      sum_done <= 1'b0;
    end else begin
      tap_d1   <= tap;
      tap_d2   <= tap_d1;
      sum_done <= tap_d2.issue && tap_d2.last;
    end
  end

  always_ff @(posedge clk) begin
    prod <= img_rdata * ker_rdata;
    if (tap_d2.issue) begin
      acc <= tap_d2.first ? term : acc + term;
    end
  end

endmodule

// File: tb/conv_sum_checker.sv
`timescale 1ns / 100ps

// Watches the command, result and register channels of the convolution core.
// It keeps its own copy of the image, the kernel and the size registers. For
// every query it computes the windowed sum and queues it, and it compares each
// result strobe, field by field, with the oldest queued sum.
module conv_sum_checker
  import zpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [OP_W-1:0]           opcode,
  input  logic [IDX_W-1:0]          row_index,
  input  logic [IDX_W-1:0]          col_index,
  input  logic signed [DATA_W-1:0]  data_value,
  input  logic                      done,
  input  logic [IDX_W-1:0]          out_row,
  input  logic [IDX_W-1:0]          out_col,
  input  logic signed [SUM_W-1:0]   conv_sum,
  input  logic                      cfg_we,
  input  logic [CIDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output int                        mismatch_count,
  output int                        awaited_count
);

  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [SUM_W-1:0]  sum;
  } conv_point_t;

  logic signed [DATA_W-1:0] pixels [0:DEF_MAX_ROWS*DEF_MAX_COLS-1];
  logic signed [DATA_W-1:0] taps [0:DEF_MAX_KERNEL*DEF_MAX_KERNEL-1];
  logic [DIM_W-1:0]         rows_reg;
  logic [DIM_W-1:0]         cols_reg;
  logic [KSIZE_W-1:0]       ksize_reg;
  conv_point_t              awaited_sums [$];
  conv_point_t              oldest;
  int                       error_tally = 0;

  // Size registers outside their range act as the nearest legal size.
  function automatic int saturate(int value, int hi);
    if (value < 1) return 1;
    if (value > hi) return hi;
    return value;
  endfunction

  function automatic logic signed [SUM_W-1:0] window_sum(int r, int c);
    int     rows, cols, ks, half, pr, pc;
    longint acc;
    rows = saturate(int'(rows_reg), DEF_MAX_ROWS);
    cols = saturate(int'(cols_reg), DEF_MAX_COLS);
    ks   = saturate(int'(ksize_reg), DEF_MAX_KERNEL);
    half = ks / 2;
    acc  = 0;
    for (int i = 0; i < ks; i++) begin
      pr = r - half + i;
      if (pr >= 0 && pr < rows) begin
        for (int j = 0; j < ks; j++) begin
          pc = c - half + j;
          if (pc >= 0 && pc < cols)
            acc += longint'(pixels[pr*DEF_MAX_COLS + pc]) *
                   longint'(taps[i*DEF_MAX_KERNEL + j]);
        end
      end
    end
    return acc[SUM_W-1:0];
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    error_tally++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      awaited_sums.delete();
      rows_reg  = DIM_W'(1);
      cols_reg  = DIM_W'(1);
      ksize_reg = KSIZE_W'(1);
    end else begin
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          REG_IMAGE_ROWS:  rows_reg  = cfg_data;
          REG_IMAGE_COLS:  cols_reg  = cfg_data;
          REG_KERNEL_SIZE: ksize_reg = cfg_data[KSIZE_W-1:0];
          default: ;
        endcase
      end

      if (done === 1'b1) begin
        if (awaited_sums.size() == 0) begin
          report_mismatch("result with no query waiting", longint'(conv_sum), 0);
        end else begin
          oldest = awaited_sums.pop_front();
          if (out_row !== oldest.row)
            report_mismatch("out_row", longint'(out_row), longint'(oldest.row));
          if (out_col !== oldest.col)
            report_mismatch("out_col", longint'(out_col), longint'(oldest.col));
          if (conv_sum !== oldest.sum)
            report_mismatch($sformatf("conv_sum at (%0d,%0d)", oldest.row, oldest.col),
                            longint'(conv_sum), longint'(oldest.sum));
        end
      end

      if (start === 1'b1 && busy === 1'b0) begin
        case (opcode)
          OP_KERNEL: begin
            if (row_index < DEF_MAX_KERNEL && col_index < DEF_MAX_KERNEL)
              taps[int'(row_index)*DEF_MAX_KERNEL + int'(col_index)] = data_value;
          end
          OP_PIXEL: begin
            if (row_index < DEF_MAX_ROWS && col_index < DEF_MAX_COLS)
              pixels[int'(row_index)*DEF_MAX_COLS + int'(col_index)] = data_value;
          end
          OP_QUERY: begin
            awaited_sums.push_back('{row_index, col_index,
                                     window_sum(int'(row_index), int'(col_index))});
          end
          default: ;
        endcase
      end
    end
    mismatch_count <= error_tally;
    awaited_count  <= awaited_sums.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

// Top of the convolution core testbench. It generates the command and
// register traffic, while the checker beside the core predicts and compares
// every result. The top only keeps track of which image and kernel entries
// have been written, so that no query ever reads an entry that holds nothing,
// and it gives the final verdict.
module testbench;
  import zpc_pkg::*;

  // Opcode and register index that the core must ignore.
  localparam logic [OP_W-1:0]   OP_IGNORED = 2'd3;
  localparam logic [CIDX_W-1:0] REG_SPARE  = 2'd3;

  // How the entries under a query window are filled before the query.
  localparam int FILL_MISSING = 0;
  localparam int FILL_MIN     = 1;
  localparam int FILL_MAX     = 2;

  // The longest correct quiet stretch is a full 16 x 16 query, or the settling
  // pause after its result; this allows several times that.
  localparam int QUIET_LIMIT = 2000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [OP_W-1:0]           opcode = OP_KERNEL;
  logic [IDX_W-1:0]          row_index = '0;
  logic [IDX_W-1:0]          col_index = '0;
  logic signed [DATA_W-1:0]  data_value = '0;
  logic                      done;
  logic [IDX_W-1:0]          out_row;
  logic [IDX_W-1:0]          out_col;
  logic signed [SUM_W-1:0]   conv_sum;
  logic                      cfg_we = 1'b0;
  logic [CIDX_W-1:0]         cfg_index = REG_IMAGE_ROWS;
  logic [CFG_W-1:0]          cfg_data = '0;

  int mismatch_count;
  int awaited_count;
  int quiet_cycles = 0;

  // Sizes in use, as the core sees them after saturation.
  int rows_used = 1;
  int cols_used = 1;
  int ks_used   = 1;

  // Entries written since reset; only these may be read by a query.
  bit pix_written [0:DEF_MAX_ROWS-1][0:DEF_MAX_COLS-1];
  bit tap_written [0:DEF_MAX_KERNEL-1][0:DEF_MAX_KERNEL-1];

  // When set, the sender puts items back to back with no gaps.
  bit steady = 1'b0;

  zero_padded_2d_convolution_core DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .row_index  (row_index),
    .col_index  (col_index),
    .data_value (data_value),
    .done       (done),
    .out_row    (out_row),
    .out_col    (out_col),
    .conv_sum   (conv_sum),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  conv_sum_checker sum_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .row_index      (row_index),
    .col_index      (col_index),
    .data_value     (data_value),
    .done           (done),
    .out_row        (out_row),
    .out_col        (out_col),
    .conv_sum       (conv_sum),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: any transfer on any channel restarts the count. If the core
  // hangs, or never returns a result, the run is ended here as a failure.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  function automatic int clamp_size(int value, int hi);
    if (value < 1) return 1;
    if (value > hi) return hi;
    return value;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value(int mode);
    if (mode == FILL_MIN) return 16'h8000;
    if (mode == FILL_MAX) return 16'h7FFF;
    return DATA_W'($urandom_range(0, 65535));
  endfunction

  // Presents one item and holds it until the core takes it. A random gap
  // comes first unless the sender is in a steady stretch. Start is only
  // lowered when a gap follows, so it is never dropped and raised again
  // within one edge.
  task automatic send_item(logic [OP_W-1:0] op, int r, int c, logic [DATA_W-1:0] value);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    opcode     <= op;
    row_index  <= r[IDX_W-1:0];
    col_index  <= c[IDX_W-1:0];
    data_value <= value;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (op == OP_KERNEL && r < DEF_MAX_KERNEL && c < DEF_MAX_KERNEL)
      tap_written[r][c] = 1'b1;
    if (op == OP_PIXEL)
      pix_written[r][c] = 1'b1;
  endtask

  // Stops sending and waits until every awaited result has come back, then
  // lets the core settle for as long as one query at the current size takes.
  // The first edge lets the checker count a query taken at this very edge.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0 || busy !== 1'b0) @(posedge clk);
    repeat (ks_used * ks_used + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_W-1:0];
    @(posedge clk);
  endtask

  // Reprograms all three sizes, plus a write to the unused index, which the
  // core must ignore. Only ever done with the core idle.
  task automatic set_sizes(int rows_raw, int cols_raw, int ks_raw);
    drain();
    write_reg(REG_IMAGE_ROWS, rows_raw);
    write_reg(REG_SPARE, $urandom_range(0, 255));
    write_reg(REG_IMAGE_COLS, cols_raw);
    write_reg(REG_KERNEL_SIZE, ks_raw);
    cfg_we <= 1'b0;
    rows_used = clamp_size(rows_raw & 8'hFF, DEF_MAX_ROWS);
    cols_used = clamp_size(cols_raw & 8'hFF, DEF_MAX_COLS);
    ks_used   = clamp_size(ks_raw & 5'h1F, DEF_MAX_KERNEL);
  endtask

  // Writes the kernel taps and pixels that a query at (r, c) will read. In
  // the min and max modes each window entry inside the image is rewritten with
  // that extreme; otherwise only entries that were never written get a random value.
  task automatic prepare_window(int r, int c, int mode);
    int half, pr, pc;
    half = ks_used / 2;
    for (int i = 0; i < ks_used; i++) begin
      pr = r - half + i;
      if (pr >= 0 && pr < rows_used) begin
        for (int j = 0; j < ks_used; j++) begin
          pc = c - half + j;
          if (pc >= 0 && pc < cols_used) begin
            if (mode != FILL_MISSING || !tap_written[i][j])
              send_item(OP_KERNEL, i, j, pick_value(mode));
            if (mode != FILL_MISSING || !pix_written[pr][pc])
              send_item(OP_PIXEL, pr, pc, pick_value(mode));
          end
        end
      end
    end
  endtask

  // A query carries random data, which the core must not use.
  task automatic query(int r, int c, int mode);
    prepare_window(r, c, mode);
    send_item(OP_QUERY, r, c, pick_value(FILL_MISSING));
  endtask

  // One random item. Most queries fall inside the image in use; some land
  // anywhere in the index range, beyond the image. Pixel and kernel writes
  // mostly target the region in use, and a share of kernel writes fall
  // outside the kernel store, where they must be dropped.
  task automatic random_item();
    int pick, r, c;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if (pick < 35) begin
        r = $urandom_range(0, rows_used - 1);
        c = $urandom_range(0, cols_used - 1);
      end else begin
        r = $urandom_range(0, 127);
        c = $urandom_range(0, 127);
      end
      query(r, c, FILL_MISSING);
    end else if (pick < 75) begin
      if (pick < 68) begin
        r = $urandom_range(0, rows_used - 1);
        c = $urandom_range(0, cols_used - 1);
      end else begin
        r = $urandom_range(0, 127);
        c = $urandom_range(0, 127);
      end
      send_item(OP_PIXEL, r, c, pick_value(FILL_MISSING));
    end else if (pick < 93) begin
      if (pick < 88) begin
        r = $urandom_range(0, ks_used - 1);
        c = $urandom_range(0, ks_used - 1);
      end else begin
        r = $urandom_range(0, 127);
        c = $urandom_range(0, 127);
      end
      send_item(OP_KERNEL, r, c, pick_value(FILL_MISSING));
    end else begin
      send_item(OP_IGNORED, $urandom_range(0, 127), $urandom_range(0, 127),
                pick_value(FILL_MISSING));
    end
  endtask

  // One phase of random traffic at one setting of the sizes. Every so often
  // the sender switches between gappy and steady stretches, and now and then
  // it pauses until every awaited result has come back.
  task automatic run_phase(int rows_raw, int cols_raw, int ks_raw, int items);
    set_sizes(rows_raw, cols_raw, ks_raw);
    for (int n = 0; n < items; n++) begin
      if (n % 40 == 0)
        steady = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 39) == 0)
        drain();
      random_item();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Sizes straight out of reset: a single pixel and a single tap.
    send_item(OP_KERNEL, 0, 0, 16'h8000);
    send_item(OP_PIXEL, 0, 0, 16'h8000);
    query(0, 0, FILL_MISSING);
    // A query far outside the image sees only padding and must give zero.
    query(127, 127, FILL_MISSING);
    // Coefficient writes beyond the kernel store are dropped.
    send_item(OP_KERNEL, 20, 3, 16'h1234);
    send_item(OP_KERNEL, 3, 127, 16'hEDCB);
    send_item(OP_IGNORED, 127, 127, 16'hFFFF);
    send_item(OP_KERNEL, 0, 0, 16'h7FFF);
    send_item(OP_PIXEL, 0, 0, 16'h7FFF);
    query(0, 0, FILL_MISSING);

    // Zero sizes must act as one.
    set_sizes(0, 0, 0);
    query(0, 0, FILL_MAX);
    query(0, 1, FILL_MISSING);

    // Sizes above the maximum saturate to 128 x 128 with a 16 x 16 kernel.
    // A corner query with the most negative values everywhere gives a large
    // positive sum over the quarter of the window inside the image, with
    // padding on two sides; the query one step inside then mixes those
    // extremes with fresh random entries.
    set_sizes(255, 255, 31);
    query(0, 0, FILL_MIN);
    query(1, 1, FILL_MISSING);

    // Random phases over a spread of shapes. The kernel size register only
    // keeps its low five bits, so 8'hE4 selects a 4 x 4 kernel.
    run_phase(3, 4, 2, 40);
    run_phase(12, 10, 5, 30);
    run_phase(1, 128, 3, 20);
    run_phase(128, 1, 8'hE4, 20);
    run_phase(2, 2, 16, 12);
    run_phase(7, 9, 7, 35);
    run_phase(200, 0, 20, 12);
    run_phase(1, 1, 1, 15);

    drain();
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
